/* src/mtms_pkg.sv */
// shared constants and types for the motor tone melody sequencer
// no dependencies; used by mtms_divider and the top level
`timescale 1ns / 1ps

package mtms_pkg;

  localparam int TABLE_DEPTH_DEF = 256;
  localparam logic [15:0] REST_CODE_DEF = 16'd0;

  localparam int NUM_W = 19;
  localparam logic [NUM_W-1:0] HALF_NUM = 19'd500000;
  localparam logic [NUM_W-1:0] TICK_US = 19'd1000;

  localparam logic [1:0] MODE_TICK  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_START = 2'd2;
  localparam logic [1:0] MODE_STOP  = 2'd3;

  localparam logic [2:0] REG_AMPLITUDE  = 3'd0;
  localparam logic [2:0] REG_GAP_TIME   = 3'd1;
  localparam logic [2:0] REG_LOOP       = 3'd2;
  localparam logic [2:0] REG_SONG_LEN   = 3'd3;
  localparam logic [2:0] REG_DRIVE_NODE = 3'd4;

  typedef struct packed {
    logic        start;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quotient;
  } div_rsp_t;

endpackage

/* src/mtms_note_ram.sv */
// note table storage: one write port, one read port, registered read data
// depends on nothing but its parameters
`timescale 1ns / 1ps

module mtms_note_ram #(
  parameter int DEPTH = 256,
  parameter int AW = 8
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/mtms_divider.sv */
// serial restoring divider for the half period, one quotient bit per cycle
// depends on mtms_pkg for the dividend constant and request/response types
`timescale 1ns / 1ps

module mtms_divider (
  input  logic               clk,
  input  logic               rst,
  input  mtms_pkg::div_req_t req,
  output mtms_pkg::div_rsp_t rsp
);

  logic                         running;
  logic [4:0]                   count;
  logic [15:0]                  dsr;
  logic [15:0]                  rem;
  logic [mtms_pkg::NUM_W-1:0]   quo;
  logic                         done;
  logic [16:0]                  trial;
  logic                         fits;

  assign trial = {rem, mtms_pkg::HALF_NUM[count]};
  assign fits  = trial >= {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= 5'(mtms_pkg::NUM_W - 1);
      end else if (running) begin
        if (count == 5'd0) begin
          running <= 1'b0;
          done    <= 1'b1;
        end else begin
          count <= count - 5'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsr <= req.divisor;
      rem <= 16'd0;
      quo <= '0;
    end else if (running) begin
      rem <= fits ? 16'(trial - {1'b0, dsr}) : trial[15:0];
      quo <= {quo[mtms_pkg::NUM_W-2:0], fits};
    end
  end

  assign rsp.done     = done;
  assign rsp.quotient = quo;

endmodule

/* src/motor_tone_melody_sequencer.sv */
// top level of the motor tone melody sequencer: control sequencer and registers
// depends on mtms_pkg, mtms_note_ram and mtms_divider
`timescale 1ns / 1ps

// Plays the note table as a square wave of speed commands, one command per
// 1 ms tick while playing (two on the tick that ends a non-looping song).
// A note write completes in the cycle it is accepted; a stop emits its command
// once the output is free; a start loads the first note. A tick steps through
// read, divide (sounding notes only, by the 19-step serial divider that forms
// the half period), calculate, load (when the next note is due) and emit. The
// note table is a one-port-read RAM with registered read data, read when a
// tick is accepted, again in the calculate step, and once on start. The input
// stalls while an item is in work; a finished command waits in the output
// register without holding up the next item. Configuration is always ready.

module motor_tone_melody_sequencer #(
  parameter int          TABLE_DEPTH = mtms_pkg::TABLE_DEPTH_DEF,
  parameter logic [15:0] REST_CODE   = mtms_pkg::REST_CODE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         mode,
  input  logic [7:0]         entry_index,
  input  logic [15:0]        entry_freq,
  input  logic [15:0]        entry_duration,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] target_rpm,
  output logic               is_playing,
  output logic               last,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_DIV   = 3'd2;
  localparam logic [2:0] S_CALC  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_EMIT2 = 3'd6;

  logic [2:0]  state;
  logic [14:0] amplitude_rpm;
  logic [15:0] gap_time;
  logic        loop_enable;
  logic [8:0]  song_length;
  logic [8:0]  note_pointer;
  logic [15:0] ms_remaining;
  logic [mtms_pkg::NUM_W-1:0] phase_acc;
  logic        wave_phase;
  logic        active;
  logic        silent;
  logic [mtms_pkg::NUM_W-1:0] half;
  logic        rd_oob;
  logic        emit_after;
  logic        second;
  logic [15:0] res_rpm;
  logic        res_play;
  logic        res_last;

  logic        accept;
  logic        out_free;
  logic        load_out;
  logic        ram_we;
  logic        ram_re;
  logic [8:0]  rd_ptr;
  logic [31:0] ram_rdata;
  logic [31:0] entry;
  logic        silent_next;
  logic [mtms_pkg::NUM_W-1:0] acc_sum;
  logic        wrap;
  logic [mtms_pkg::NUM_W-1:0] acc_next;
  logic        phase_next;
  logic [15:0] rpm_calc;
  logic [15:0] ms_dec;
  logic [9:0]  ptr_inc;
  logic        song_end;
  logic [8:0]  ptr_adv;

  mtms_pkg::div_req_t div_req;
  mtms_pkg::div_rsp_t div_rsp;

  assign cfg_ready = 1'b1;
  assign in_stall  = state != S_IDLE;
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign load_out  = ((state == S_EMIT) || (state == S_EMIT2)) && out_free;

  // note table access
  assign ram_we = accept && (mode == mtms_pkg::MODE_WRITE) && (32'(entry_index) < TABLE_DEPTH);
  assign entry  = rd_oob ? 32'd0 : ram_rdata;

  always_comb begin
    ram_re = 1'b0;
    rd_ptr = note_pointer;
    case (state)
      S_IDLE: begin
        if (accept && (mode == mtms_pkg::MODE_TICK) && active) begin
          ram_re = 1'b1;
        end else if (accept && (mode == mtms_pkg::MODE_START) && (song_length != 9'd0)) begin
          ram_re = 1'b1;
          rd_ptr = 9'd0;
        end
      end
      S_CALC: begin
        ram_re = 1'b1;
        rd_ptr = ptr_adv;
      end
      default: begin
        ram_re = 1'b0;
      end
    endcase
  end

  mtms_note_ram #(
    .DEPTH(TABLE_DEPTH),
    .AW   (AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(AW'(32'(entry_index))),
    .wdata({entry_duration, entry_freq}),
    .re   (ram_re),
    .raddr(AW'(32'(rd_ptr))),
    .rdata(ram_rdata)
  );

  // half period divider
  assign silent_next = ((gap_time != 16'd0) && (ms_remaining <= gap_time))
                       || (entry[15:0] == REST_CODE) || (entry[15:0] == 16'd0);
  assign div_req.start   = (state == S_READ) && !silent_next;
  assign div_req.divisor = entry[15:0];

  mtms_divider u_div (
    .clk(clk),
    .rst(rst),
    .req(div_req),
    .rsp(div_rsp)
  );

  // wave and note timing
  assign acc_sum    = phase_acc + mtms_pkg::TICK_US;
  assign wrap       = acc_sum >= half;
  assign acc_next   = wrap ? acc_sum - half : acc_sum;
  assign phase_next = wave_phase ^ wrap;
  assign rpm_calc   = silent ? 16'd0
                    : (phase_next ? {1'b0, amplitude_rpm} : 16'd0 - {1'b0, amplitude_rpm});
  assign ms_dec     = (ms_remaining != 16'd0) ? ms_remaining - 16'd1 : 16'd0;
  assign ptr_inc    = {1'b0, note_pointer} + 10'd1;
  assign song_end   = ptr_inc >= {1'b0, song_length};
  assign ptr_adv    = song_end ? 9'd0 : ptr_inc[8:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      amplitude_rpm <= 15'd0;
      gap_time      <= 16'd0;
      loop_enable   <= 1'b0;
      song_length   <= 9'd0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        mtms_pkg::REG_AMPLITUDE:  amplitude_rpm <= cfg_data[14:0];
        mtms_pkg::REG_GAP_TIME:   gap_time      <= cfg_data;
        mtms_pkg::REG_LOOP:       loop_enable   <= cfg_data[0];
        mtms_pkg::REG_SONG_LEN:   song_length   <= cfg_data[8:0];
        mtms_pkg::REG_DRIVE_NODE: begin
          // address of the drive only, no effect on the commands
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      note_pointer <= 9'd0;
      ms_remaining <= 16'd0;
      phase_acc    <= '0;
      wave_phase   <= 1'b0;
      active       <= 1'b0;
      emit_after   <= 1'b0;
      second       <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            case (mode)
              mtms_pkg::MODE_TICK: begin
                if (active) begin
                  state <= S_READ;
                end
              end
              mtms_pkg::MODE_START: begin
                note_pointer <= 9'd0;
                phase_acc    <= '0;
                wave_phase   <= 1'b0;
                active       <= song_length != 9'd0;
                emit_after   <= 1'b0;
                if (song_length != 9'd0) begin
                  state <= S_LOAD;
                end
              end
              mtms_pkg::MODE_STOP: begin
                active   <= 1'b0;
                res_rpm  <= 16'd0;
                res_play <= 1'b0;
                res_last <= 1'b1;
                second   <= 1'b0;
                state    <= S_EMIT;
              end
              default: begin
              end
            endcase
          end
        end
        S_READ: begin
          silent <= silent_next;
          state  <= silent_next ? S_CALC : S_DIV;
        end
        S_DIV: begin
          if (div_rsp.done) begin
            half  <= div_rsp.quotient;
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (!silent) begin
            phase_acc  <= acc_next;
            wave_phase <= phase_next;
          end
          ms_remaining <= ms_dec;
          res_rpm      <= rpm_calc;
          res_play     <= 1'b1;
          if (ms_dec != 16'd0) begin
            res_last <= 1'b1;
            second   <= 1'b0;
            state    <= S_EMIT;
          end else if (song_end && !loop_enable) begin
            note_pointer <= ptr_inc[8:0];
            active       <= 1'b0;
            res_last     <= 1'b0;
            second       <= 1'b1;
            state        <= S_EMIT;
          end else begin
            note_pointer <= ptr_adv;
            res_last     <= 1'b1;
            second       <= 1'b0;
            emit_after   <= 1'b1;
            state        <= S_LOAD;
          end
        end
        S_LOAD: begin
          ms_remaining <= entry[31:16];
          phase_acc    <= '0;
          wave_phase   <= 1'b0;
          state        <= emit_after ? S_EMIT : S_IDLE;
        end
        S_EMIT: begin
          if (out_free) begin
            target_rpm <= res_rpm;
            is_playing <= res_play;
            last       <= res_last;
            state      <= second ? S_EMIT2 : S_IDLE;
          end
        end
        S_EMIT2: begin
          if (out_free) begin
            target_rpm <= 16'sd0;
            is_playing <= 1'b0;
            last       <= 1'b1;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ram_re) begin
      rd_oob <= 32'(rd_ptr) >= TABLE_DEPTH;
    end
  end

endmodule

/* src/mtms_checker.sv */
// port-level checks on the motor tone melody sequencer, bound to the top level
// depends on motor_tone_melody_sequencer ports only
`timescale 1ns / 1ps

module mtms_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [15:0] target_rpm,
  input logic               is_playing,
  input logic               last
);

  // held beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(target_rpm)
      && $stable(is_playing) && $stable(last))
    else $error("output beat changed while stalled");

  // a beat that ends play carries zero speed
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_playing |-> target_rpm == 16'sd0)
    else $error("nonzero speed on a stopped beat");

  // a stopped beat is always the final one of its item
  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_playing |-> last)
    else $error("stopped beat not marked last");

  // a non-final playing beat is followed by the stop beat
  a_pair: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last |=> ##[0:0] 1'b1 ##0
      (!out_valid || (!is_playing && last)))
    else $error("first beat of a pair not followed by the stop beat");

  // nothing shown right after reset
  a_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

bind motor_tone_melody_sequencer mtms_checker u_mtms_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .target_rpm(target_rpm),
  .is_playing(is_playing),
  .last      (last)
);
